// ===== rtl/core/fabik_pkg.sv =====
package fabik_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int LEN_WIDTH   = 31;
	localparam int ITER_WIDTH  = 8;
	localparam int MAG_W       = (COORD_WIDTH + 1 > 32) ? COORD_WIDTH + 1 : 32;
	localparam int SUM_W       = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;
	localparam int PROD_W      = 2 * LEN_WIDTH;
	localparam int ROOT_W      = 64;
	localparam int CNT_W       = $clog2(PROD_W);

	localparam logic [LEN_WIDTH-1:0]  FIRST_LEN_RST  = LEN_WIDTH'(10485760);
	localparam logic [LEN_WIDTH-1:0]  SECOND_LEN_RST = LEN_WIDTH'(10485760);
	localparam logic [ITER_WIDTH-1:0] ITER_RST       = ITER_WIDTH'(8);

	localparam logic [1:0] REG_FIRST_LEN  = 2'd0;
	localparam logic [1:0] REG_SECOND_LEN = 2'd1;
	localparam logic [1:0] REG_ITER       = 2'd2;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
	} point_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] base_x;
		logic signed [COORD_WIDTH-1:0] base_y;
		logic signed [COORD_WIDTH-1:0] middle_x;
		logic signed [COORD_WIDTH-1:0] middle_y;
		logic signed [COORD_WIDTH-1:0] tip_x;
		logic signed [COORD_WIDTH-1:0] tip_y;
		logic signed [COORD_WIDTH-1:0] target_x;
		logic signed [COORD_WIDTH-1:0] target_y;
	} item_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] solved_middle_x;
		logic signed [COORD_WIDTH-1:0] solved_middle_y;
		logic signed [COORD_WIDTH-1:0] solved_tip_x;
		logic signed [COORD_WIDTH-1:0] solved_tip_y;
		logic                          degenerate_seen;
	} result_t;

	typedef struct packed {
		logic                 start;
		logic [LEN_WIDTH-1:0] len;
		point_t               s;
		point_t               m;
	} place_req_t;

	typedef struct packed {
		logic   done;
		logic   degen;
		point_t p;
	} place_rsp_t;

endpackage

// ===== rtl/core/fabik_place.sv =====
module fabik_place
	import fabik_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  place_req_t req,
	output place_rsp_t rsp
);

	typedef enum logic [3:0] {
		P_IDLE, P_DIFF, P_NORM, P_SQX, P_SQY, P_SUM, P_SQRT,
		P_MUL, P_LOAD, P_DIV, P_STORE, P_DONE
	} pstate_t;

	localparam logic [MAG_W-1:0] NORM_HIGH = MAG_W'(64'd1 << 31);
	localparam logic [MAG_W-1:0] NORM_LOW  = MAG_W'(64'd1 << 30);
	localparam logic signed [SUM_W-1:0] C_MAX =
		{{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] C_MIN =
		{{(SUM_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

	pstate_t                  state_q;
	point_t                   s_q;
	point_t                   m_q;
	logic [LEN_WIDTH-1:0]     len_q;
	logic [MAG_W-1:0]         ax_q, ay_q;
	logic                     negx_q, negy_q;
	logic [PROD_W-1:0]        prod_q;
	logic [ROOT_W-1:0]        n_q, root_q, bit_q;
	logic [PROD_W-1:0]        dq_q;
	logic [31:0]              rem_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     axis_q;
	logic [LEN_WIDTH-1:0]     qx_q;
	point_t                   out_q;
	logic                     degen_q;

	logic signed [COORD_WIDTH:0] dx, dy;
	logic [COORD_WIDTH:0]        mx, my;
	logic [MAG_W-1:0]            big;
	logic [LEN_WIDTH-1:0]        mul_a, mul_b;
	logic [ROOT_W-1:0]           trial;
	logic [32:0]                 rem_sh, rem_sub;
	logic                        ge;

	function automatic logic signed [COORD_WIDTH-1:0] settle(
		input logic signed [COORD_WIDTH-1:0] s,
		input logic [LEN_WIDTH-1:0] q,
		input logic neg
	);
		logic signed [SUM_W-1:0] v;
		v = neg ? (SUM_W'(s) - $signed(SUM_W'(q))) : (SUM_W'(s) + $signed(SUM_W'(q)));
		if (v > C_MAX) begin
			return C_MAX[COORD_WIDTH-1:0];
		end else if (v < C_MIN) begin
			return C_MIN[COORD_WIDTH-1:0];
		end
		return v[COORD_WIDTH-1:0];
	endfunction

	assign dx = (COORD_WIDTH+1)'(m_q.x) - (COORD_WIDTH+1)'(s_q.x);
	assign dy = (COORD_WIDTH+1)'(m_q.y) - (COORD_WIDTH+1)'(s_q.y);
	assign mx = dx[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dx) : dx;
	assign my = dy[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dy) : dy;
	assign big = (ax_q > ay_q) ? ax_q : ay_q;
	assign trial = root_q + bit_q;
	assign rem_sh = {rem_q, dq_q[PROD_W-1]};
	assign ge = rem_sh >= {1'b0, root_q[31:0]};
	assign rem_sub = rem_sh - {1'b0, root_q[31:0]};

	always_comb begin
		mul_a = len_q;
		mul_b = axis_q ? ay_q[LEN_WIDTH-1:0] : ax_q[LEN_WIDTH-1:0];
		if (state_q == P_SQX) begin
			mul_a = ax_q[LEN_WIDTH-1:0];
			mul_b = ax_q[LEN_WIDTH-1:0];
		end else if (state_q == P_SQY) begin
			mul_a = ay_q[LEN_WIDTH-1:0];
			mul_b = ay_q[LEN_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
		end else begin
			prod_q <= mul_a * mul_b;
			unique case (state_q)
				P_IDLE: begin
					if (req.start) begin
						s_q <= req.s;
						m_q <= req.m;
						len_q <= req.len;
						state_q <= P_DIFF;
					end
				end
				P_DIFF: begin
					ax_q <= MAG_W'(mx);
					ay_q <= MAG_W'(my);
					negx_q <= dx[COORD_WIDTH];
					negy_q <= dy[COORD_WIDTH];
					axis_q <= 1'b0;
					if (mx == '0 && my == '0) begin
						out_q <= s_q;
						degen_q <= 1'b1;
						state_q <= P_DONE;
					end else begin
						degen_q <= 1'b0;
						state_q <= P_NORM;
					end
				end
				P_NORM: begin
					if (big >= NORM_HIGH) begin
						ax_q <= ax_q >> 1;
						ay_q <= ay_q >> 1;
					end else if (big < NORM_LOW) begin
						ax_q <= ax_q << 1;
						ay_q <= ay_q << 1;
					end else begin
						state_q <= P_SQX;
					end
				end
				P_SQX: state_q <= P_SQY;
				P_SQY: begin
					n_q <= ROOT_W'(prod_q);
					state_q <= P_SUM;
				end
				P_SUM: begin
					n_q <= n_q + ROOT_W'(prod_q);
					root_q <= '0;
					bit_q <= ROOT_W'(64'd1 << 62);
					state_q <= P_SQRT;
				end
				P_SQRT: begin
					if (n_q >= trial) begin
						n_q <= n_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= P_MUL;
					end
				end
				P_MUL: state_q <= P_LOAD;
				P_LOAD: begin
					dq_q <= prod_q;
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= P_DIV;
				end
				P_DIV: begin
					rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
					dq_q <= {dq_q[PROD_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(PROD_W - 1)) begin
						state_q <= P_STORE;
					end
				end
				P_STORE: begin
					if (!axis_q) begin
						qx_q <= dq_q[LEN_WIDTH-1:0];
						axis_q <= 1'b1;
						state_q <= P_MUL;
					end else begin
						out_q.x <= settle(s_q.x, qx_q, negx_q);
						out_q.y <= settle(s_q.y, dq_q[LEN_WIDTH-1:0], negy_q);
						state_q <= P_DONE;
					end
				end
				P_DONE: state_q <= P_IDLE;
				default: state_q <= P_IDLE;
			endcase
		end
	end

	assign rsp.done = (state_q == P_DONE);
	assign rsp.degen = degen_q;
	assign rsp.p = out_q;

endmodule

// ===== rtl/core/fabrik_two_link_ik_solver.sv =====
// Two-link planar inverse kinematics solver using backward and forward reaching rounds.
// An input transaction on item/item_valid/item_stall carries base, middle, tip and target
// points in signed Q16.16. One result transaction on result/result_valid/result_stall
// returns the solved middle and tip points and a flag for any zero-length pull.
// The cfg channel writes link lengths and the iteration setting; cfg_ready is always high.
// Each round runs four point placements on one shared placement unit that owns a
// 31x31 multiplier, a one-bit-per-cycle square root and a one-bit-per-cycle divider.
// A placement runs two 62-step divisions and 32 root steps plus up to 30 normalizing
// shifts, and a zero-length pull skips all of them. An item runs
// floor(iteration_count / 2) rounds, four at the reset setting.
// The block holds item_stall high from acceptance until the result is registered.
// A finished result waits in the output register while result_stall is high, and
// the next item is accepted meanwhile. Reset clears the sequencer and output valid
// and restores the register reset values.
module fabrik_two_link_ik_solver
	import fabik_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [LEN_WIDTH-1:0]  cfg_data
);

	typedef enum logic [1:0] {T_IDLE, T_ISSUE, T_WAIT, T_OUT} tstate_t;

	tstate_t               state_q;
	logic [LEN_WIDTH-1:0]  first_len_q, second_len_q;
	logic [ITER_WIDTH-1:0] iter_q;
	point_t                base_q, mid_q, tip_q, target_q;
	logic                  flag_q;
	logic [ITER_WIDTH-2:0] round_q;
	logic [1:0]            step_q;
	logic                  result_valid_q;
	result_t               result_q;
	place_req_t            req;
	place_rsp_t            rsp;

	always_comb begin
		req.start = (state_q == T_ISSUE);
		case (step_q)
			2'd0: begin
				req.len = second_len_q;
				req.s = target_q;
				req.m = mid_q;
			end
			2'd1: begin
				req.len = first_len_q;
				req.s = mid_q;
				req.m = base_q;
			end
			2'd2: begin
				req.len = first_len_q;
				req.s = base_q;
				req.m = mid_q;
			end
			default: begin
				req.len = second_len_q;
				req.s = mid_q;
				req.m = tip_q;
			end
		endcase
	end

	fabik_place u_place (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_len_q <= FIRST_LEN_RST;
			second_len_q <= SECOND_LEN_RST;
			iter_q <= ITER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIRST_LEN: first_len_q <= cfg_data;
				REG_SECOND_LEN: second_len_q <= cfg_data;
				REG_ITER: iter_q <= cfg_data[ITER_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && state_q != T_OUT) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (item_valid) begin
						base_q <= '{x: item.base_x, y: item.base_y};
						mid_q <= '{x: item.middle_x, y: item.middle_y};
						tip_q <= '{x: item.tip_x, y: item.tip_y};
						target_q <= '{x: item.target_x, y: item.target_y};
						flag_q <= 1'b0;
						round_q <= iter_q[ITER_WIDTH-1:1];
						step_q <= 2'd0;
						state_q <= (iter_q[ITER_WIDTH-1:1] == '0) ? T_OUT : T_ISSUE;
					end
				end
				T_ISSUE: state_q <= T_WAIT;
				T_WAIT: begin
					if (rsp.done) begin
						flag_q <= flag_q | rsp.degen;
						step_q <= step_q + 2'd1;
						case (step_q)
							2'd0: begin
								mid_q <= rsp.p;
								tip_q <= target_q;
							end
							2'd2: mid_q <= rsp.p;
							2'd3: tip_q <= rsp.p;
							default: ;
						endcase
						if (step_q == 2'd3) begin
							round_q <= round_q - 1'b1;
							state_q <= (round_q == (ITER_WIDTH-1)'(1)) ? T_OUT : T_ISSUE;
						end else begin
							state_q <= T_ISSUE;
						end
					end
				end
				T_OUT: begin
					if (!result_valid_q || !result_stall) begin
						result_q.solved_middle_x <= mid_q.x;
						result_q.solved_middle_y <= mid_q.y;
						result_q.solved_tip_x <= tip_q.x;
						result_q.solved_tip_y <= tip_q.y;
						result_q.degenerate_seen <= flag_q;
						result_valid_q <= 1'b1;
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign item_stall = (state_q != T_IDLE);
	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// ===== rtl/core/fabik_checker.sv =====
module fabik_checker
	import fabik_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("block took no busy cycle after accepting an item");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !$rose(result_valid))
		else $error("result appeared in the cycle after acceptance");

	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !item_stall)
		else $error("new result while block still busy");

endmodule

bind fabrik_two_link_ik_solver fabik_checker u_fabik_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
